@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/core/ured_pkg.sv @@
// Types and constants shared by the ultrasonic echo range filter modules.
package ured_pkg;

    typedef enum logic [1:0] {
        FUNC_RISE    = 2'd0,
        FUNC_FALL    = 2'd1,
        FUNC_UPDATE  = 2'd2,
        FUNC_TRIGGER = 2'd3
    } ured_func_t;

    typedef enum logic [1:0] {
        CFG_SCALE     = 2'd0,
        CFG_MIN_DIST  = 2'd1,
        CFG_MAX_DIST  = 2'd2,
        CFG_ALPHA     = 2'd3
    } ured_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_FILT,
        ST_EMIT
    } ured_state_t;

    localparam int DIST_BITS   = 20;
    localparam int WIDTH_BITS  = 28;
    localparam int PROD_BITS   = WIDTH_BITS + 16;
    localparam int FILT_BITS   = 29;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [DIST_BITS-1:0] DIST_MAX   = 20'hFFFFF;
    localparam logic [8:0]           ONE_Q8     = 9'd256;
    localparam logic [FILT_BITS-1:0] ROUND_Q8   = 29'd128;

    localparam logic [15:0]          CM_RESET    = 16'd1124;
    localparam logic [DIST_BITS-1:0] MIN_RESET   = 20'd512;
    localparam logic [DIST_BITS-1:0] MAX_RESET   = 20'd102400;
    localparam logic [8:0]           ALPHA_RESET = 9'd77;

    // One classified event as it travels from the front end to the back end.
    typedef struct packed {
        ured_func_t              func;
        logic [31:0]             stamp;
        logic                    echo_ready;
        logic                    over;
        logic [WIDTH_BITS-1:0]   width;
    } ured_cmd_t;

    typedef struct packed {
        logic [15:0]          scale_q16;
        logic [DIST_BITS-1:0] min_dist;
        logic [DIST_BITS-1:0] max_dist;
        logic [8:0]           alpha;
    } ured_cfg_t;

    typedef struct packed {
        logic                 ok;
        logic [DIST_BITS-1:0] raw_dist;
        logic [DIST_BITS-1:0] filtered_dist;
        logic                 reading_valid;
        logic [31:0]          stamp;
        logic                 trig_pulse;
    } ured_res_t;

endpackage

@@ rtl/core/ultrasonic_echo_range_filter.sv @@
// Update requests pass ST_MUL, ST_CHECK, ST_FILT and ST_EMIT, other events only ST_EMIT;
// m_tvalid is registered. The back-end sequencer takes one request at a time; a queue of
// QUEUE_DEPTH entries lets requests arrive in bursts, and back-pressure holds it in ST_EMIT.
// Reset (synchronous, aresetn low) clears the echo record, the filter state, the queue and
// m_tvalid, and loads the default configuration; no clearing pass is needed.
module ultrasonic_echo_range_filter #(
    parameter int TIME_BITS   = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] time_us
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [19:0] raw_dist_q8, [39:20] filtered_dist_q8, [71:40] stamp_us
    output logic [2:0]  m_tuser,   // [0] ok, [1] reading_valid, [2] trig_pulse
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [ured_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    import ured_pkg::*;

    localparam int CMD_BITS = $bits(ured_cmd_t);

    ured_cfg_t           cfg_reg, cfg_next;
    ured_cmd_t           push_cmd, pop_cmd;
    logic [CMD_BITS-1:0] pop_bits;
    logic                push, pop, queue_full, queue_empty;
    ured_res_t           res;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (ured_cfg_idx_t'(cfg_index))
                CFG_SCALE:     cfg_next.scale_q16 = cfg_data[15:0];
                CFG_MIN_DIST:  cfg_next.min_dist  = cfg_data[DIST_BITS-1:0];
                CFG_MAX_DIST:  cfg_next.max_dist  = cfg_data[DIST_BITS-1:0];
                CFG_ALPHA:     cfg_next.alpha     = cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_q16 <= CM_RESET;
            cfg_reg.min_dist  <= MIN_RESET;
            cfg_reg.max_dist  <= MAX_RESET;
            cfg_reg.alpha     <= ALPHA_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ured_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_func    (s_tuser),
        .in_time    (s_tdata),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    ured_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_bits),
        .empty     (queue_empty)
    );

    assign pop_cmd = ured_cmd_t'(pop_bits);

    ured_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res)
    );

    assign m_tdata = {res.stamp, res.filtered_dist, res.raw_dist};
    assign m_tuser = {res.trig_pulse, res.reading_valid, res.ok};

endmodule

@@ rtl/core/ured_fifo.sv @@
// Small register queue between the front end and the back end.
module ured_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/ured_front.sv @@
// Front end: accepts events, keeps the echo record and queues classified commands.
module ured_front #(
    parameter int TIME_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [1:0]         in_func,
    input  logic [31:0]        in_time,
    input  logic               queue_full,
    output logic               in_ready,
    output logic               push,
    output ured_pkg::ured_cmd_t push_cmd
);

    import ured_pkg::*;

    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] end_reg,   end_next;
    logic                 ready_reg, ready_next;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] diff;
    logic [63:0]          diff_wide;
    ured_func_t           func;

    assign in_ready  = !queue_full;
    assign push      = in_valid && !queue_full;
    assign func      = ured_func_t'(in_func);
    assign t         = TIME_BITS'(in_time);
    assign diff      = end_reg - start_reg;
    assign diff_wide = 64'(diff);

    // Echo widths of 2^28 us or more saturate unless the scale is zero, so only the low bits
    // go on to the multiplier together with an overflow flag.
    always_comb begin
        push_cmd.func       = func;
        push_cmd.stamp      = 32'(t);
        push_cmd.echo_ready = ready_reg;
        push_cmd.over       = |diff_wide[63:WIDTH_BITS];
        push_cmd.width      = diff_wide[WIDTH_BITS-1:0];
    end

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        ready_next = ready_reg;
        if (push) begin
            unique case (func)
                FUNC_RISE: begin
                    start_next = t;
                end
                FUNC_FALL: begin
                    end_next   = t;
                    ready_next = 1'b1;
                end
                FUNC_TRIGGER: begin
                    start_next = '0;
                    end_next   = '0;
                    ready_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= '0;
            ready_reg <= 1'b0;
        end else begin
            start_reg <= start_next;
            end_reg   <= end_next;
            ready_reg <= ready_next;
        end
    end

endmodule

@@ rtl/core/ured_back.sv @@
// Back end: distance conversion, range check, smoothing filter and result register.
module ured_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ured_pkg::ured_cfg_t cfg,
    input  logic                queue_empty,
    input  ured_pkg::ured_cmd_t pop_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output ured_pkg::ured_res_t out_res
);

    import ured_pkg::*;

    ured_state_t           state_reg, state_next;
    ured_cmd_t             cmd_reg,   cmd_next;
    logic [PROD_BITS-1:0]  prod_reg,  prod_next;
    logic [DIST_BITS-1:0]  dist_reg,  dist_next;
    logic                  accept_reg, accept_next;
    logic [FILT_BITS-1:0]  ma_reg, ma_next;
    logic [FILT_BITS-1:0]  mb_reg, mb_next;
    logic                  valid_reg, valid_next;
    logic [DIST_BITS-1:0]  raw_reg,   raw_next;
    logic [DIST_BITS-1:0]  filt_reg,  filt_next;
    logic [31:0]           stamp_reg, stamp_next;
    logic                  out_valid_reg, out_valid_next;
    ured_res_t             res_reg,   res_next;
    logic [8:0]            alpha_sat;
    logic [FILT_BITS-1:0]  sum;
    logic                  is_update;

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign alpha_sat = (cfg.alpha > ONE_Q8) ? ONE_Q8 : cfg.alpha;
    assign sum       = ma_reg + mb_reg + ROUND_Q8;
    assign is_update = (cmd_reg.func == FUNC_UPDATE);

    always_comb begin
        state_next     = state_reg;
        pop            = 1'b0;
        cmd_next       = cmd_reg;
        prod_next      = prod_reg;
        dist_next      = dist_reg;
        accept_next    = accept_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        valid_next     = valid_reg;
        raw_next       = raw_reg;
        filt_next      = filt_reg;
        stamp_next     = stamp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    pop        = 1'b1;
                    cmd_next   = pop_cmd;
                    state_next = (pop_cmd.func == FUNC_UPDATE) ? ST_MUL : ST_EMIT;
                end
            end
            ST_MUL: begin
                prod_next  = cmd_reg.width * cfg.scale_q16;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (cfg.scale_q16 == '0) begin
                    dist_next = '0;
                end else if (cmd_reg.over || (|prod_reg[PROD_BITS-1:WIDTH_BITS])) begin
                    dist_next = DIST_MAX;
                end else begin
                    dist_next = prod_reg[WIDTH_BITS-1:8];
                end
                accept_next = cmd_reg.echo_ready
                           && (dist_next >= cfg.min_dist)
                           && (dist_next <= cfg.max_dist);
                state_next  = ST_FILT;
            end
            ST_FILT: begin
                ma_next    = (ONE_Q8 - alpha_sat) * filt_reg;
                mb_next    = alpha_sat * dist_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // State is committed only when the result can be written out.
                if (!out_valid_reg || out_ready) begin
                    if (is_update) begin
                        if (accept_reg) begin
                            raw_next   = dist_reg;
                            filt_next  = valid_reg ? sum[WIDTH_BITS-1:8] : dist_reg;
                            valid_next = 1'b1;
                            stamp_next = cmd_reg.stamp;
                        end else begin
                            valid_next = 1'b0;
                        end
                    end
                    out_valid_next         = 1'b1;
                    res_next.ok            = is_update && accept_reg;
                    res_next.raw_dist      = raw_next;
                    res_next.filtered_dist = filt_next;
                    res_next.reading_valid = valid_next;
                    res_next.stamp         = stamp_next;
                    res_next.trig_pulse    = (cmd_reg.func == FUNC_TRIGGER);
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= 1'b0;
            raw_reg       <= '0;
            filt_reg      <= '0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            raw_reg       <= raw_next;
            filt_reg      <= filt_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        prod_reg   <= prod_next;
        dist_reg   <= dist_next;
        accept_reg <= accept_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        res_reg    <= res_next;
    end

endmodule

@@ rtl/core/ured_checker.sv @@
// Port-level checker for the ultrasonic echo range filter, bound to the top level.
`include "assert_macros.svh"

module ured_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result keeps its request and its payload.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_CLK(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))

    // An accepted reading always leaves the filter holding a valid value.
    `ASSERT_CLK(a_ok_valid, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tuser[1])

    // Only update requests can accept a reading, so ok never comes with a trigger.
    `ASSERT_CLK(a_ok_not_trig, aclk, aresetn, m_tvalid |-> !(m_tuser[0] && m_tuser[2]))

    // Nothing is offered in the cycle after reset.
    `ASSERT_CLK_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid)

endmodule

bind ultrasonic_echo_range_filter ured_checker u_ured_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/ultrasonic_echo_range_filter_tb.sv @@
// Self-checking testbench for the ultrasonic echo range filter: directed table, then random events.
`timescale 1ns / 1ps

module ultrasonic_echo_range_filter_tb;
    import ured_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] time_us
    logic [1:0]  s_tuser = '0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // [19:0] raw_dist_q8, [39:20] filtered_dist_q8, [71:40] stamp_us
    logic [2:0]  m_tuser;        // [0] ok, [1] reading_valid, [2] trig_pulse
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    ultrasonic_echo_range_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Register copies and echo/filter state of the range predictor.
    logic [15:0]          cm_q16   = CM_RESET;
    logic [DIST_BITS-1:0] min_q8   = MIN_RESET;
    logic [DIST_BITS-1:0] max_q8   = MAX_RESET;
    logic [8:0]           alpha_q8 = ALPHA_RESET;
    logic [31:0]          echo_t0 = '0;
    logic [31:0]          echo_t1 = '0;
    logic                 echo_seen = 1'b0;
    logic                 reading_ok = 1'b0;
    logic [DIST_BITS-1:0] raw_q8 = '0;
    logic [DIST_BITS-1:0] filt_q8 = '0;
    logic [31:0]          stamp_q = '0;

    typedef struct {
        ured_func_t fn;
        logic [31:0] t;
        bit          typed;
        ured_res_t   res;
    } probe_t;

    probe_t    probes[$];
    ured_res_t pending_results[$];
    int        mismatches = 0;
    int        n_sent = 0;
    int        n_results = 0;
    int        cycle_count = 0;
    bit        steady_run = 1'b0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ultrasonic_echo_range_filter_tb: FAIL");
            $finish;
        end
    end

    task automatic flag_error(input string what);
        $display("MISMATCH result %0d: %s", n_results, what);
        mismatches++;
    endtask

    // Advances the echo record and the filter by one event and returns its result.
    function automatic ured_res_t ranging_step(input ured_func_t fn, input logic [31:0] t);
        ured_res_t   r;
        logic [31:0] span;
        logic [63:0] prod;
        logic [63:0] keep_w;
        logic [63:0] new_w;
        logic [63:0] mix;
        logic [DIST_BITS-1:0] range_q8;
        r = '0;
        case (fn)
            FUNC_RISE: echo_t0 = t;
            FUNC_FALL: begin
                echo_t1 = t;
                echo_seen = 1'b1;
            end
            FUNC_UPDATE: begin
                if (!echo_seen) begin
                    reading_ok = 1'b0;
                end else begin
                    span = echo_t1 - echo_t0;
                    prod = (64'(span) * 64'(cm_q16)) >> 8;
                    range_q8 = (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_BITS-1:0];
                    if (range_q8 < min_q8 || range_q8 > max_q8) begin
                        reading_ok = 1'b0;
                    end else begin
                        raw_q8 = range_q8;
                        if (!reading_ok) begin
                            filt_q8 = range_q8;
                        end else begin
                            new_w  = (alpha_q8 > ONE_Q8) ? 64'(ONE_Q8) : 64'(alpha_q8);
                            keep_w = 64'(ONE_Q8) - new_w;
                            mix = (keep_w * 64'(filt_q8) + new_w * 64'(range_q8) + 64'd128) >> 8;
                            filt_q8 = (mix > 64'(DIST_MAX)) ? DIST_MAX : mix[DIST_BITS-1:0];
                        end
                        reading_ok = 1'b1;
                        stamp_q = t;
                        r.ok = 1'b1;
                    end
                end
            end
            default: begin
                echo_seen = 1'b0;
                echo_t0 = '0;
                echo_t1 = '0;
                r.trig_pulse = 1'b1;
            end
        endcase
        r.raw_dist      = raw_q8;
        r.filtered_dist = filt_q8;
        r.reading_valid = reading_ok;
        r.stamp         = stamp_q;
        return r;
    endfunction

    task automatic offer_event(input ured_func_t fn, input logic [31:0] t,
                               input bit typed, input ured_res_t given);
        int gap;
        ured_res_t predicted;
        gap = 0;
        if (!steady_run && $urandom_range(0, 99) < 32) gap = $urandom_range(1, 4);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
        predicted = ranging_step(fn, t);
        pending_results.push_back(typed ? given : predicted);
        n_sent++;
    endtask

    task automatic write_reg(input ured_cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] v);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SCALE:     cm_q16 = v[15:0];
            CFG_MIN_DIST:  min_q8 = v;
            CFG_MAX_DIST:  max_q8 = v;
            default:       alpha_q8 = v[8:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly rise/fall/update sequences, some led by a trigger, with echo widths aimed at
    // the accepted range and its edges; the rest is loose events in any order.
    task automatic run_random(input int n_events);
        int          first;
        int          pick;
        logic [31:0] t0;
        logic [63:0] w;
        logic [63:0] goal;
        first = n_sent;
        while (n_sent - first < n_events) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if ($urandom_range(0, 3) == 0) offer_event(FUNC_TRIGGER, $urandom, 1'b0, '0);
                t0 = $urandom;
                pick = $urandom_range(0, 9);
                if (cm_q16 == 0 || pick >= 8) begin
                    w = 64'($urandom);
                end else if (pick < 6) begin
                    if (max_q8 >= min_q8)
                        goal = 64'(min_q8) + 64'($urandom_range(0, max_q8 - min_q8));
                    else
                        goal = 64'($urandom_range(0, DIST_MAX));
                    w = (goal << 8) / 64'(cm_q16);
                end else if (pick == 6) begin
                    w = ((64'(min_q8) << 8) + 64'(cm_q16) - 1) / 64'(cm_q16)
                        - 64'($urandom_range(0, 1));
                end else begin
                    w = (((64'(max_q8) + 1) << 8) - 1) / 64'(cm_q16) + 64'($urandom_range(0, 1));
                end
                offer_event(FUNC_RISE, t0, 1'b0, '0);
                offer_event(FUNC_FALL, t0 + w[31:0], 1'b0, '0);
                repeat ($urandom_range(1, 3)) offer_event(FUNC_UPDATE, $urandom, 1'b0, '0);
            end else begin
                offer_event(ured_func_t'($urandom_range(0, 3)), $urandom, 1'b0, '0);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic void add_row(input ured_func_t fn, input logic [31:0] t,
                                    input bit typed, input ured_res_t res);
        probe_t p;
        p.fn = fn;
        p.t = t;
        p.typed = typed;
        p.res = res;
        probes.push_back(p);
    endfunction

    // Result side: checks each accepted result, then sets ready for the next cycle.
    initial begin
        ured_res_t got;
        ured_res_t want;
        int        hold_left;
        bit        held_off;
        hold_left = 0;
        held_off = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.raw_dist      = m_tdata[19:0];
                got.filtered_dist = m_tdata[39:20];
                got.stamp         = m_tdata[71:40];
                got.ok            = m_tuser[0];
                got.reading_valid = m_tuser[1];
                got.trig_pulse    = m_tuser[2];
                if (pending_results.size() == 0) begin
                    flag_error("result with no request waiting");
                end else begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok)
                        flag_error($sformatf("ok got %0d expected %0d", got.ok, want.ok));
                    if (got.raw_dist !== want.raw_dist)
                        flag_error($sformatf("raw_dist got %h expected %h",
                                             got.raw_dist, want.raw_dist));
                    if (got.filtered_dist !== want.filtered_dist)
                        flag_error($sformatf("filtered_dist got %h expected %h",
                                             got.filtered_dist, want.filtered_dist));
                    if (got.reading_valid !== want.reading_valid)
                        flag_error($sformatf("reading_valid got %0d expected %0d",
                                             got.reading_valid, want.reading_valid));
                    if (got.stamp !== want.stamp)
                        flag_error($sformatf("stamp got %h expected %h", got.stamp, want.stamp));
                    if (got.trig_pulse !== want.trig_pulse)
                        flag_error($sformatf("trig_pulse got %0d expected %0d",
                                             got.trig_pulse, want.trig_pulse));
                end
                n_results++;
            end
            @(negedge aclk);
            // One long hold-off lets the internal queue fill and back-pressure the input.
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held_off && n_results >= 100) begin
                held_off = 1'b1;
                hold_left = 300;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady_run || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    initial begin
        ured_res_t idle_res;
        ured_res_t trig_res;
        idle_res = '0;
        trig_res = '0;
        trig_res.trig_pulse = 1'b1;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Nothing has been measured yet, so these results hold zero state; the trigger sets only trig_pulse.
        add_row(FUNC_UPDATE,  32'h0000_0000, 1'b1, idle_res);
        add_row(FUNC_TRIGGER, 32'h0000_0005, 1'b1, trig_res);
        add_row(FUNC_RISE,    32'hFFFF_FFF0, 1'b1, idle_res);
        add_row(FUNC_FALL,    32'h0000_0100, 1'b1, idle_res);
        // The echo above wraps the timestamp; first accepted reading seeds the filter.
        add_row(FUNC_UPDATE,  32'hFFFF_FFFF, 1'b0, '0);
        add_row(FUNC_UPDATE,  32'h1234_5678, 1'b0, '0);
        add_row(FUNC_RISE,    32'h8000_0000, 1'b0, '0);
        add_row(FUNC_FALL,    32'h8000_3000, 1'b0, '0);
        add_row(FUNC_UPDATE,  32'h8000_4000, 1'b0, '0);
        // Zero width falls below the minimum.
        add_row(FUNC_RISE,    32'h0000_0000, 1'b0, '0);
        add_row(FUNC_FALL,    32'h0000_0000, 1'b0, '0);
        add_row(FUNC_UPDATE,  32'h5555_5555, 1'b0, '0);
        // Full-scale width saturates the distance above the maximum.
        add_row(FUNC_RISE,    32'h0000_0000, 1'b0, '0);
        add_row(FUNC_FALL,    32'hFFFF_FFFF, 1'b0, '0);
        add_row(FUNC_UPDATE,  32'hAAAA_AAAA, 1'b0, '0);
        add_row(FUNC_RISE,    32'h0000_1000, 1'b0, '0);
        add_row(FUNC_FALL,    32'h0000_2000, 1'b0, '0);
        add_row(FUNC_UPDATE,  32'h0000_3000, 1'b0, '0);
        // An update after a trigger has no echo to measure.
        add_row(FUNC_TRIGGER, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(FUNC_UPDATE,  32'h0000_4000, 1'b0, '0);
        foreach (probes[i]) offer_event(probes[i].fn, probes[i].t, probes[i].typed, probes[i].res);
        run_random(70);

        write_reg(CFG_SCALE,     20'hFFFFF);
        write_reg(CFG_MIN_DIST,  20'h00000);
        write_reg(CFG_MAX_DIST,  20'hFFFFF);
        write_reg(CFG_ALPHA,     20'd256);
        run_random(70);

        write_reg(CFG_SCALE,     20'd0);
        write_reg(CFG_ALPHA,     20'd0);
        run_random(40);

        // Minimum above maximum: every update is rejected.
        write_reg(CFG_SCALE,     20'd1124);
        write_reg(CFG_MIN_DIST,  20'hFFFFF);
        write_reg(CFG_MAX_DIST,  20'h00000);
        write_reg(CFG_ALPHA,     20'hFFFFF);
        run_random(40);

        write_reg(CFG_SCALE,     20'($urandom_range(1, 65535)));
        write_reg(CFG_MIN_DIST,  20'($urandom_range(0, 50000)));
        write_reg(CFG_MAX_DIST,  20'($urandom_range(60000, DIST_MAX)));
        write_reg(CFG_ALPHA,     20'($urandom_range(0, 511)));
        steady_run = 1'b1;
        run_random(100);
        steady_run = 1'b0;

        write_reg(CFG_SCALE,     20'd1124);
        write_reg(CFG_MIN_DIST,  20'd512);
        write_reg(CFG_MAX_DIST,  20'd102400);
        write_reg(CFG_ALPHA,     20'd300);
        run_random(80);

        write_reg(CFG_ALPHA, 20'd1);
        run_random(60);

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("ultrasonic_echo_range_filter_tb: PASS");
        else
            $display("ultrasonic_echo_range_filter_tb: FAIL");
        $finish;
    end

endmodule
